[rtl/core/cse_pkg.sv]
package cse_pkg;

   // Frame and signal limits.
   localparam int FRAME_BYTES     = 8;
   localparam int MAX_SIGNAL_BITS = 32;
   // Bytes that one walk can touch: up to 7 bits of start offset plus 32 signal bits.
   localparam int WIN_BYTES       = 5;
   localparam int WIN_BITS        = WIN_BYTES * 8;

   // Raw patterns that mark a signal as not available.
   localparam logic [31:0] ONES_8  = 32'h0000_00FF;
   localparam logic [31:0] ONES_16 = 32'h0000_FFFF;
   localparam logic [31:0] ONES_24 = 32'h00FF_FFFF;
   localparam logic [31:0] ONES_32 = 32'hFFFF_FFFF;

   localparam logic signed [63:0] PHYS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] PHYS_MIN = 64'sh8000_0000_0000_0000;

   // One decode request: payload plus signal description.
   typedef struct packed {
      logic [63:0]         payload;
      logic [5:0]          start_bit;
      logic [5:0]          bit_length;
      logic                motorola_order;
      logic                reverse_bytes;
      logic                offset_first;
      logic signed [31:0]  scale;
      logic signed [47:0]  bias;
   } req_type;

   // Extracted field on its way to the scaling pipeline.
   typedef struct packed {
      logic [31:0]         raw_value;
      logic                all_ones_marker;
      logic                out_of_frame;
      logic                offset_first;
      logic signed [31:0]  scale;
      logic signed [47:0]  bias;
   } field_type;

   // Finished result.
   typedef struct packed {
      logic [31:0]         raw_value;
      logic signed [63:0]  physical_value;
      logic                all_ones_marker;
      logic                out_of_frame;
   } rsp_type;

endpackage

[rtl/core/cse_extract.sv]
module cse_extract (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cse_pkg::req_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output cse_pkg::field_type out_data
);
   import cse_pkg::*;

   localparam int STAGES = 2;

   typedef struct packed {
      logic [WIN_BITS-1:0] window;
      logic [2:0]          bit0;
      logic [5:0]          len;
      logic                out_of_frame;
      logic                offset_first;
      logic signed [31:0]  scale;
      logic signed [47:0]  bias;
   } gather_type;

   logic [STAGES-1:0] v_ff, v_in, rdy;
   gather_type        s1_ff, s1_in;
   field_type         s2_ff, s2_in;

   // Stage control: a stage loads when it is empty or its word moves on.
   always_comb begin
      for (int k = STAGES - 1; k >= 0; k--) begin
         if (k == STAGES - 1) begin
            rdy[k] = !v_ff[k] || out_ready;
         end else begin
            rdy[k] = !v_ff[k] || rdy[k+1];
         end
      end
      v_in[0] = rdy[0] ? in_valid : v_ff[0];
      v_in[1] = rdy[1] ? v_ff[0] : v_ff[1];
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[STAGES-1];
   assign out_data  = s2_ff;

   // Stage 1: fetch the bytes in walk order, apply the optional byte reversal.
   logic [2:0] start_byte;
   logic [5:0] len_c;
   logic [5:0] len_up;
   logic [2:0] nbytes;
   logic       rev_on;
   logic [5:0] last_bit;
   logic [2:0] last_byte;
   logic [3:0] pos_w    [WIN_BYTES];
   logic       inside_w [WIN_BYTES];
   logic [7:0] byte_w   [WIN_BYTES];

   always_comb begin
      logic [2:0] src;
      start_byte = in_data.start_bit[5:3];
      len_c      = (in_data.bit_length > 6'(MAX_SIGNAL_BITS)) ? 6'(MAX_SIGNAL_BITS)
                                                              : in_data.bit_length;
      len_up     = len_c + 6'd7;
      nbytes     = len_up[5:3];
      rev_on     = in_data.reverse_bytes && (nbytes > 3'd1);
      last_bit   = {3'b000, in_data.start_bit[2:0]} + len_c - 6'd1;
      last_byte  = last_bit[5:3];

      for (int j = 0; j < WIN_BYTES; j++) begin
         if (in_data.motorola_order) begin
            pos_w[j]    = {1'b0, start_byte} - 4'(j);
            inside_w[j] = 3'(j) <= start_byte;
         end else begin
            pos_w[j]    = {1'b0, start_byte} + 4'(j);
            inside_w[j] = !pos_w[j][3];
         end
         byte_w[j] = inside_w[j] ? in_data.payload[{pos_w[j][2:0], 3'b000} +: 8] : 8'h00;
      end

      s1_in = '0;
      for (int j = 0; j < WIN_BYTES; j++) begin
         src = nbytes - 3'd1 - 3'(j);
         if (rev_on && (3'(j) < nbytes)) begin
            s1_in.window[j*8 +: 8] = inside_w[j] ? byte_w[src] : 8'h00;
         end else begin
            s1_in.window[j*8 +: 8] = byte_w[j];
         end
      end

      // Reversal touches a subset of the walked bytes, so the walk's span decides.
      if (len_c == 6'd0) begin
         s1_in.out_of_frame = 1'b0;
      end else if (in_data.motorola_order) begin
         s1_in.out_of_frame = last_byte > start_byte;
      end else begin
         s1_in.out_of_frame = ({1'b0, start_byte} + {1'b0, last_byte}) > 4'(FRAME_BYTES - 1);
      end

      s1_in.bit0         = in_data.start_bit[2:0];
      s1_in.len          = len_c;
      s1_in.offset_first = in_data.offset_first;
      s1_in.scale        = in_data.scale;
      s1_in.bias         = in_data.bias;
   end

   // Stage 2: align to the start bit, cut to length, detect the all-ones marker.
   logic [WIN_BITS-1:0] shifted;
   logic [32:0]         mask_wide;
   logic [31:0]         raw;

   always_comb begin
      shifted   = s1_ff.window >> s1_ff.bit0;
      mask_wide = ~(33'h1_FFFF_FFFF << s1_ff.len);
      raw       = shifted[31:0] & mask_wide[31:0];

      s2_in.raw_value       = raw;
      s2_in.all_ones_marker = (s1_ff.len == 6'd8  && raw == ONES_8)  ||
                              (s1_ff.len == 6'd16 && raw == ONES_16) ||
                              (s1_ff.len == 6'd24 && raw == ONES_24) ||
                              (s1_ff.len == 6'd32 && raw == ONES_32);
      s2_in.out_of_frame    = s1_ff.out_of_frame;
      s2_in.offset_first    = s1_ff.offset_first;
      s2_in.scale           = s1_ff.scale;
      s2_in.bias            = s1_ff.bias;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_ff <= s1_in;
      end
      if (rdy[1]) begin
         s2_ff <= s2_in;
      end
   end

endmodule

[rtl/core/cse_scale.sv]
module cse_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cse_pkg::field_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output cse_pkg::rsp_type    out_data
);
   import cse_pkg::*;

   localparam int STAGES = 4;

   typedef struct packed {
      logic signed [49:0]  operand;
      logic [31:0]         raw_value;
      logic                all_ones_marker;
      logic                out_of_frame;
      logic                offset_first;
      logic signed [31:0]  scale;
      logic signed [47:0]  bias;
   } opnd_type;

   typedef struct packed {
      logic signed [64:0]  prod_lo;
      logic signed [49:0]  prod_hi;
      logic [31:0]         raw_value;
      logic                all_ones_marker;
      logic                out_of_frame;
      logic                offset_first;
      logic signed [47:0]  bias;
   } part_type;

   typedef struct packed {
      logic signed [81:0]  product;
      logic [31:0]         raw_value;
      logic                all_ones_marker;
      logic                out_of_frame;
      logic                offset_first;
      logic signed [47:0]  bias;
   } prod_type;

   logic [STAGES-1:0] v_ff, v_in, rdy;
   opnd_type          s3_ff, s3_in;
   part_type          s4_ff, s4_in;
   prod_type          s5_ff, s5_in;
   rsp_type           s6_ff, s6_in;

   always_comb begin
      for (int k = STAGES - 1; k >= 0; k--) begin
         if (k == STAGES - 1) begin
            rdy[k] = !v_ff[k] || out_ready;
         end else begin
            rdy[k] = !v_ff[k] || rdy[k+1];
         end
      end
      for (int k = 0; k < STAGES; k++) begin
         if (k == 0) begin
            v_in[k] = rdy[k] ? in_valid : v_ff[k];
         end else begin
            v_in[k] = rdy[k] ? v_ff[k-1] : v_ff[k];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[STAGES-1];
   assign out_data  = s6_ff;

   // Stage 3: multiplicand is the raw value, or raw in Q.16 plus the bias.
   always_comb begin
      if (in_data.offset_first) begin
         s3_in.operand = $signed({2'b00, in_data.raw_value, 16'h0000})
                       + $signed({{2{in_data.bias[47]}}, in_data.bias});
      end else begin
         s3_in.operand = $signed({18'h0_0000, in_data.raw_value});
      end
      s3_in.raw_value       = in_data.raw_value;
      s3_in.all_ones_marker = in_data.all_ones_marker;
      s3_in.out_of_frame    = in_data.out_of_frame;
      s3_in.offset_first    = in_data.offset_first;
      s3_in.scale           = in_data.scale;
      s3_in.bias            = in_data.bias;
   end

   // Stage 4: two partial products, low 32 bits unsigned and high 18 bits signed.
   always_comb begin
      s4_in.prod_lo         = $signed({1'b0, s3_ff.operand[31:0]}) * s3_ff.scale;
      s4_in.prod_hi         = $signed(s3_ff.operand[49:32]) * s3_ff.scale;
      s4_in.raw_value       = s3_ff.raw_value;
      s4_in.all_ones_marker = s3_ff.all_ones_marker;
      s4_in.out_of_frame    = s3_ff.out_of_frame;
      s4_in.offset_first    = s3_ff.offset_first;
      s4_in.bias            = s3_ff.bias;
   end

   // Stage 5: join the partial products into the full product.
   always_comb begin
      s5_in.product         = $signed({s4_ff.prod_hi, 32'h0000_0000})
                            + $signed({{17{s4_ff.prod_lo[64]}}, s4_ff.prod_lo});
      s5_in.raw_value       = s4_ff.raw_value;
      s5_in.all_ones_marker = s4_ff.all_ones_marker;
      s5_in.out_of_frame    = s4_ff.out_of_frame;
      s5_in.offset_first    = s4_ff.offset_first;
      s5_in.bias            = s4_ff.bias;
   end

   // Stage 6: add the bias or drop the extra fraction (floor), then saturate; a flagged word passes through unscaled.
   logic signed [82:0] total;
   logic               fits;

   always_comb begin
      if (s5_ff.offset_first) begin
         total = $signed({{17{s5_ff.product[81]}}, s5_ff.product[81:16]});
      end else begin
         total = $signed({s5_ff.product[81], s5_ff.product})
               + $signed({{35{s5_ff.bias[47]}}, s5_ff.bias});
      end
      fits = (&total[82:63]) || !(|total[82:63]);

      if (s5_ff.all_ones_marker) begin
         s6_in.physical_value = $signed({16'h0000, s5_ff.raw_value, 16'h0000});
      end else if (fits) begin
         s6_in.physical_value = total[63:0];
      end else if (total[82]) begin
         s6_in.physical_value = PHYS_MIN;
      end else begin
         s6_in.physical_value = PHYS_MAX;
      end
      s6_in.raw_value       = s5_ff.raw_value;
      s6_in.all_ones_marker = s5_ff.all_ones_marker;
      s6_in.out_of_frame    = s5_ff.out_of_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s3_ff <= s3_in;
      end
      if (rdy[1]) begin
         s4_ff <= s4_in;
      end
      if (rdy[2]) begin
         s5_ff <= s5_in;
      end
      if (rdy[3]) begin
         s6_ff <= s6_in;
      end
   end

   // A flagged word carries its raw value unscaled in Q.16.
   a_ones_unscaled: assert property (@(posedge clock) disable iff (reset)
      (out_valid && s6_ff.all_ones_marker)
         |-> (s6_ff.physical_value == $signed({16'h0000, s6_ff.raw_value, 16'h0000})))
      else $error("flagged result is not the unscaled raw value");

   // The marker is only raised for one of the all-ones patterns.
   a_ones_pattern: assert property (@(posedge clock) disable iff (reset)
      (out_valid && s6_ff.all_ones_marker)
         |-> (s6_ff.raw_value == ONES_8 || s6_ff.raw_value == ONES_16 ||
              s6_ff.raw_value == ONES_24 || s6_ff.raw_value == ONES_32))
      else $error("all-ones marker on a raw value that is not all ones");

   // With every stage full and the output stalled, nothing more may enter.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&v_ff) && !out_ready) |-> !in_ready)
      else $error("word accepted into a full, stalled pipeline");

   // A stage that holds a word and cannot pass it on keeps it.
   a_stage_keep: assert property (@(posedge clock) disable iff (reset)
      (v_ff[1] && !rdy[2]) |=> v_ff[1])
      else $error("stalled word lost in the multiply stage");

endmodule

[rtl/core/can_signal_extract_scale.sv]
// CAN signal decoder. Each request word carries one 8-byte CAN payload and one
// DBC-style signal description; each response word carries the extracted raw field
// and its scaled physical value. The raw field is gathered from start_bit upward,
// moving to the next byte up (Intel) or down (Motorola) after bit 7 of a byte, with
// an optional reversal of the signal's bytes first. Lengths above 32 count as 32.
// Scaling is raw*scale+bias or (raw+bias)*scale with a Q16.16 factor and a Q32.16
// offset, floored to Q48.16 and saturated to 64 bits. A raw value of all ones at 8,
// 16, 24 or 32 bits is passed through unscaled and flagged; any byte read outside
// the frame reads as zero and raises out_of_frame. The block is a six-stage
// pipeline: two stages gather and align the field, four compute the product (the
// 50 by 32 bit multiply is split into two partial products and joined one stage
// later) and add or round. It takes one word per clock while the output is not
// stalled. The first stage loads at the edge that accepts a request; the word then
// moves through the stages in order and waits in the last one until it is taken.
// Back-pressure on the response side holds each stage in place; empty stages still
// fill, so the input keeps accepting until the pipeline holds six words.
module can_signal_extract_scale (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // payload[63:0], start_bit[69:64], bit_length[75:70], scale[107:76],
   // bias[155:108], zero fill[159:156]
   input  logic [159:0]  req_tdata,
   // motorola_order[0], reverse_bytes[1], offset_first[2]
   input  logic [2:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // raw_value[31:0], physical_value[95:32]
   output logic [95:0]   rsp_tdata,
   // all_ones_marker[0], out_of_frame[1]
   output logic [1:0]    rsp_tuser
);
   import cse_pkg::*;

   req_type   req;
   field_type field;
   rsp_type   rsp;
   logic      field_valid;
   logic      field_ready;

   // Split the request word into its fields; the zero fill is not used.
   always_comb begin
      req.payload        = req_tdata[63:0];
      req.start_bit      = req_tdata[69:64];
      req.bit_length     = req_tdata[75:70];
      req.scale          = $signed(req_tdata[107:76]);
      req.bias           = $signed(req_tdata[155:108]);
      req.motorola_order = req_tuser[0];
      req.reverse_bytes  = req_tuser[1];
      req.offset_first   = req_tuser[2];
   end

   cse_extract u_extract (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req),
      .out_valid (field_valid),
      .out_ready (field_ready),
      .out_data  (field)
   );

   cse_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (field_valid),
      .in_ready  (field_ready),
      .in_data   (field),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   // Pack the response word.
   assign rsp_tdata = {rsp.physical_value, rsp.raw_value};
   assign rsp_tuser = {rsp.out_of_frame, rsp.all_ones_marker};

endmodule

[bench/tb_decode_pkg.sv]
`timescale 1ns / 100ps

package tb_decode_pkg;

   import cse_pkg::*;

   // Keeps the expected decode of every accepted request word and compares the
   // response words against them in order.
   class decode_checker;

      localparam int MAX_PRINTED = 40;

      rsp_type expected_decodes[$];
      int      error_count;
      int      decoded_count;
      int      oof_count;
      int      ones_count;
      int      offset_first_count;

      function new();
         error_count        = 0;
         decoded_count      = 0;
         oof_count          = 0;
         ones_count         = 0;
         offset_first_count = 0;
      endfunction

      // Gathers the raw field and scales it exactly as the block should.
      function rsp_type decode_signal(req_type r);
         logic [7:0]         frame_bytes [0:FRAME_BYTES-1];
         int                 sig_len;
         int                 sig_bytes;
         int                 byte_idx;
         int                 bit_pos;
         int                 dst;
         int                 src;
         logic [7:0]         v;
         logic [31:0]        raw;
         logic               oof;
         logic               ones;
         logic signed [95:0] raw_w;
         logic signed [95:0] scale_w;
         logic signed [95:0] bias_w;
         logic signed [95:0] acc;
         rsp_type            res;

         sig_len = r.bit_length;
         if (sig_len > MAX_SIGNAL_BITS) begin
            sig_len = MAX_SIGNAL_BITS;
         end
         sig_bytes = (sig_len + 7) / 8;
         byte_idx  = r.start_bit / 8;
         bit_pos   = r.start_bit % 8;
         raw       = '0;
         oof       = 1'b0;

         for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_bytes[i] = r.payload[8*i +: 8];
         end

         // Byte reversal reads the original payload and writes the working copy.
         if (r.reverse_bytes && sig_bytes > 1) begin
            for (int i = 0; i < sig_bytes; i++) begin
               if (!r.motorola_order) begin
                  dst = byte_idx + i;
                  src = byte_idx + sig_bytes - 1 - i;
               end else begin
                  dst = byte_idx - i;
                  src = byte_idx - sig_bytes + 1 + i;
               end
               if (src < 0 || src >= FRAME_BYTES) begin
                  v   = '0;
                  oof = 1'b1;
               end else begin
                  v = r.payload[8*src +: 8];
               end
               if (dst >= 0 && dst < FRAME_BYTES) begin
                  frame_bytes[dst] = v;
               end else begin
                  oof = 1'b1;
               end
            end
         end

         for (int i = 0; i < sig_len; i++) begin
            if (bit_pos > 7) begin
               byte_idx = r.motorola_order ? byte_idx - 1 : byte_idx + 1;
               bit_pos  = 0;
            end
            if (byte_idx >= 0 && byte_idx < FRAME_BYTES) begin
               v = frame_bytes[byte_idx];
            end else begin
               v   = '0;
               oof = 1'b1;
            end
            raw[i]  = v[bit_pos];
            bit_pos = bit_pos + 1;
         end

         ones = (sig_len == 8  && raw == ONES_8)  || (sig_len == 16 && raw == ONES_16) ||
                (sig_len == 24 && raw == ONES_24) || (sig_len == 32 && raw == ONES_32);

         raw_w   = {64'd0, raw};
         scale_w = {{64{r.scale[31]}}, r.scale};
         bias_w  = {{48{r.bias[47]}}, r.bias};

         res.raw_value       = raw;
         res.all_ones_marker = ones;
         res.out_of_frame    = oof;
         if (ones) begin
            res.physical_value = {16'd0, raw, 16'd0};
         end else begin
            if (!r.offset_first) begin
               acc = raw_w * scale_w + bias_w;
            end else begin
               acc = (((raw_w <<< 16) + bias_w) * scale_w) >>> 16;
            end
            if (acc[95:63] == '0 || acc[95:63] == '1) begin
               res.physical_value = acc[63:0];
            end else begin
               res.physical_value = acc[95] ? PHYS_MIN : PHYS_MAX;
            end
         end
         return res;
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         error_count++;
         if (error_count <= MAX_PRINTED) begin
            $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
         end
      endtask

      task note_request(req_type r);
         expected_decodes.push_back(decode_signal(r));
         if (r.offset_first) begin
            offset_first_count++;
         end
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (expected_decodes.size() == 0) begin
            report("response with nothing outstanding", got.raw_value, '0);
         end else begin
            want = expected_decodes.pop_front();
            decoded_count++;
            if (want.out_of_frame) oof_count++;
            if (want.all_ones_marker) ones_count++;
            if (got.raw_value !== want.raw_value) begin
               report("raw_value", got.raw_value, want.raw_value);
            end
            if (got.physical_value !== want.physical_value) begin
               report("physical_value", got.physical_value, want.physical_value);
            end
            if (got.all_ones_marker !== want.all_ones_marker) begin
               report("all_ones_marker", got.all_ones_marker, want.all_ones_marker);
            end
            if (got.out_of_frame !== want.out_of_frame) begin
               report("out_of_frame", got.out_of_frame, want.out_of_frame);
            end
         end
      endtask

      function int pending_count();
         return expected_decodes.size();
      endfunction

   endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 100ps

// Top level of the signal decoder bench. A request word carries a CAN payload and
// a signal description; the bench predicts the response word of every accepted
// request and compares the responses in order. Both sides idle at random, and at
// times the response side holds off for a long stretch so that the six-stage
// pipeline fills and stalls the request side.
module tb_top;

   import cse_pkg::*;
   import tb_decode_pkg::*;

   localparam int      TOTAL_WORDS  = 1250;
   localparam int      LONG_HOLD    = 150;
   localparam int      DRAIN_CYCLES = 30;
   localparam int      CYCLE_LIMIT  = 400000;
   localparam logic signed [31:0] Q16_ONE   = 32'sh0001_0000;
   localparam logic signed [31:0] SCALE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SCALE_MIN = 32'sh8000_0000;
   localparam logic signed [47:0] BIAS_MAX  = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] BIAS_MIN  = 48'sh8000_0000_0000;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata  = '0;
   logic [2:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   decode_checker board = new();

   // Largest gap each side may draw before its next word; zero means no idling.
   int sender_max_gap   = 0;
   int receiver_max_gap = 0;
   // Set by the stimulus to ask the response side for one long hold-off.
   bit hold_pending     = 1'b0;
   int cycle_count      = 0;

   req_type seen_req;
   rsp_type seen_rsp;

   always #10 clock = ~clock;

   can_signal_extract_scale i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Watch both channels at every rising edge. Inputs change only through
   // nonblocking assignments, so the values seen here are the ones the block
   // sampled at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen_req.payload        = req_tdata[63:0];
            seen_req.start_bit      = req_tdata[69:64];
            seen_req.bit_length     = req_tdata[75:70];
            seen_req.scale          = req_tdata[107:76];
            seen_req.bias           = req_tdata[155:108];
            seen_req.motorola_order = req_tuser[0];
            seen_req.reverse_bytes  = req_tuser[1];
            seen_req.offset_first   = req_tuser[2];
            board.note_request(seen_req);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp.raw_value       = rsp_tdata[31:0];
            seen_rsp.physical_value  = rsp_tdata[95:32];
            seen_rsp.all_ones_marker = rsp_tuser[0];
            seen_rsp.out_of_frame    = rsp_tuser[1];
            board.check_response(seen_rsp);
         end
      end
   end

   // A hung pipeline or a lost response ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   function automatic req_type make_req(logic [63:0] payload, logic [5:0] start_bit,
                                        logic [5:0] bit_length, logic moto, logic rev,
                                        logic ofs_first, logic signed [31:0] scale,
                                        logic signed [47:0] bias);
      req_type r;
      r.payload        = payload;
      r.start_bit      = start_bit;
      r.bit_length     = bit_length;
      r.motorola_order = moto;
      r.reverse_bytes  = rev;
      r.offset_first   = ofs_first;
      r.scale          = scale;
      r.bias           = bias;
      return r;
   endfunction

   // Offers one request word after a random gap and returns at the edge where it
   // is taken. Called at a rising edge, so valid is assigned at most once per step.
   task automatic send_request(req_type r);
      int gap;
      gap = $urandom_range(0, sender_max_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, r.bias, r.scale, r.bit_length, r.start_bit, r.payload};
      req_tuser  <= {r.offset_first, r.reverse_bytes, r.motorola_order};
      do @(posedge clock); while (!req_tready);
   endtask

   // Shapes rsp_tready: before each response word a random number of stalled
   // cycles, or one long hold-off when the stimulus asks for it.
   task automatic run_receiver();
      int stall;
      rsp_tready <= 1'b1;
      @(posedge clock);
      forever begin
         stall = $urandom_range(0, receiver_max_gap);
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall        = LONG_HOLD;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end
         do @(posedge clock); while (!rsp_tvalid);
      end
   endtask

   initial begin
      req_type     directed_q[$];
      req_type     r;
      int          kind;
      int          len_eff;
      int          hi_start;
      logic [63:0] sr;

      // Extremes of the fields, both byte orders, reversal, both scaling modes
      // and every special case of the decode.
      // Plain Intel byte and the all-ones patterns at 8, 16, 24 and 32 bits.
      directed_q.push_back(make_req(64'h0123_4567_89AB_CDEF, 0, 8, 0, 0, 0, Q16_ONE, 0));
      directed_q.push_back(make_req(64'h0000_0000_0000_00FF, 0, 8, 0, 0, 0, Q16_ONE, 5));
      directed_q.push_back(make_req('1, 0, 16, 0, 0, 0, SCALE_MAX, BIAS_MAX));
      directed_q.push_back(make_req('1, 8, 24, 0, 0, 1, -Q16_ONE, BIAS_MIN));
      directed_q.push_back(make_req('1, 32, 32, 0, 0, 1, SCALE_MIN, 0));
      directed_q.push_back(make_req('1, 39, 32, 1, 1, 0, 3, -7));
      // Ones at a length that is not a whole byte count are scaled as usual.
      directed_q.push_back(make_req('1, 0, 31, 0, 0, 0, SCALE_MAX, BIAS_MAX));
      // Saturation in both directions for both orders of offset and scale.
      directed_q.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFE, 0, 32, 0, 0, 0,
                                    SCALE_MAX, BIAS_MAX));
      directed_q.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFE, 0, 32, 0, 0, 0,
                                    SCALE_MIN, BIAS_MIN));
      directed_q.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFE, 0, 32, 0, 0, 1,
                                    SCALE_MAX, BIAS_MAX));
      directed_q.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFE, 0, 32, 0, 0, 1,
                                    SCALE_MIN, BIAS_MAX));
      directed_q.push_back(make_req('0, 0, 32, 0, 0, 1, SCALE_MIN, BIAS_MIN));
      // Negative product with a remainder rounds toward minus infinity.
      directed_q.push_back(make_req(64'h1, 0, 1, 0, 0, 1, -3, 1));
      // Zero length and lengths above the maximum.
      directed_q.push_back(make_req('1, 17, 0, 0, 0, 0, Q16_ONE, -5));
      directed_q.push_back(make_req(64'hA5A5_5A5A_C3C3_3C3C, 0, 63, 0, 0, 0, Q16_ONE, 0));
      directed_q.push_back(make_req(64'hA5A5_5A5A_C3C3_3C3C, 63, 33, 1, 0, 1, Q16_ONE, 9));
      // Walks that leave the frame below and above, and reversals that do.
      directed_q.push_back(make_req(64'hFFFF_FFFF_FFFF_FF81, 7, 16, 1, 0, 0, Q16_ONE, 0));
      directed_q.push_back(make_req(64'hF0E1_D2C3_B4A5_9687, 60, 32, 0, 0, 0, Q16_ONE, 0));
      directed_q.push_back(make_req(64'hF0E1_D2C3_B4A5_9687, 48, 32, 0, 1, 0, Q16_ONE, 0));
      directed_q.push_back(make_req(64'hF0E1_D2C3_B4A5_9687, 8, 24, 1, 1, 0, Q16_ONE, 0));
      // Reversals inside the frame, and one over a single byte, which is a no-op.
      directed_q.push_back(make_req(64'hF0E1_D2C3_B4A5_9687, 63, 32, 1, 1, 0, Q16_ONE, 0));
      directed_q.push_back(make_req(64'hF0E1_D2C3_B4A5_9687, 3, 16, 0, 1, 1, 2, 1));
      directed_q.push_back(make_req(64'hF0E1_D2C3_B4A5_9687, 5, 8, 0, 1, 0, Q16_ONE, 0));
      // The very last bit of the frame.
      directed_q.push_back(make_req(64'h8000_0000_0000_0000, 63, 1, 0, 0, 0, -1, 0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      fork
         run_receiver();
      join_none

      foreach (directed_q[i]) begin
         send_request(directed_q[i]);
      end

      for (int n = 0; n < TOTAL_WORDS - directed_q.size(); n++) begin
         // New idling pattern for each block of a hundred words; some blocks run
         // with no gaps at all on one or both sides.
         if (n % 100 == 0) begin
            case ($urandom_range(0, 3))
               0: sender_max_gap = 0;
               1: sender_max_gap = 2;
               default: sender_max_gap = 13;
            endcase
            case ($urandom_range(0, 3))
               0: receiver_max_gap = 0;
               1: receiver_max_gap = 2;
               default: receiver_max_gap = 13;
            endcase
         end
         // Twice in the run the response side holds off while words keep coming
         // back to back, so the pipeline fills and req_tready drops.
         if (n == 300 || n == 900) begin
            sender_max_gap = 0;
            hold_pending   = 1'b1;
         end

         kind = $urandom_range(0, 99);
         r.payload = {$urandom, $urandom};
         if (kind < 12) begin
            r.payload = '1;
         end else if (kind < 16) begin
            r.payload = '0;
         end

         case ($urandom_range(0, 9))
            7: r.bit_length = 6'(8 * $urandom_range(1, 4));
            8: r.bit_length = ($urandom_range(0, 1) != 0) ? 6'd0 : 6'($urandom_range(33, 63));
            9: r.bit_length = 6'($urandom);
            default: r.bit_length = 6'($urandom_range(1, 32));
         endcase
         len_eff = (r.bit_length > MAX_SIGNAL_BITS) ? MAX_SIGNAL_BITS : r.bit_length;

         r.motorola_order = 1'($urandom);
         r.reverse_bytes  = 1'($urandom);
         r.offset_first   = 1'($urandom);

         // Most signals lie inside the frame; the rest start anywhere.
         if (kind < 75) begin
            if (!r.motorola_order) begin
               hi_start    = (64 - len_eff > 63) ? 63 : 64 - len_eff;
               r.start_bit = 6'($urandom_range(0, hi_start));
            end else begin
               r.start_bit = 6'($urandom_range(32, 63));
            end
         end else begin
            r.start_bit = 6'($urandom);
         end

         case ($urandom_range(0, 3))
            0: r.scale = $urandom;
            1: r.scale = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
            2: begin
               case ($urandom_range(0, 4))
                  0: r.scale = SCALE_MAX;
                  1: r.scale = SCALE_MIN;
                  2: r.scale = 0;
                  3: r.scale = -1;
                  default: r.scale = Q16_ONE;
               endcase
            end
            default: r.scale = $signed(32'($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000;
         endcase

         sr = {$urandom, $urandom};
         case ($urandom_range(0, 3))
            0: r.bias = sr[47:0];
            1: r.bias = $signed({{32{sr[31]}}, sr[15:0]});
            2: r.bias = ($urandom_range(0, 1) != 0) ? BIAS_MAX : BIAS_MIN;
            default: r.bias = $signed({{20{sr[27]}}, sr[27:0]});
         endcase

         send_request(r);
      end
      req_tvalid <= 1'b0;

      while (board.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d decoded signals, %0d of them reaching outside the frame,",
               board.decoded_count, board.oof_count);
      $display("%0d flagged as all ones and %0d scaled with the offset applied first.",
               board.ones_count, board.offset_first_count);
      if (board.error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
